// ===== rtl/core/atm_shaper_parameter_calc_macros.svh =====
// Assertion macros for the shaper parameter calculator checker
`ifndef ATM_SHAPER_PARAMETER_CALC_MACROS_SVH
`define ATM_SHAPER_PARAMETER_CALC_MACROS_SVH

// Check cons in the same cycle as ante
`define ATM_SPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atm_spc: assertion failed");

// Check cons in the cycle after ante
`define ATM_SPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atm_spc: assertion failed");

`endif

// ===== rtl/core/atm_spc_pkg.sv =====
// Types and constants of the ATM shaper parameter calculator
package atm_spc_pkg;

    localparam int DIVIDEND_W = 30;
    localparam int DIVISOR_W  = 24;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_BUS_CLOCK_HZ   = 3'd0,
        REG_TIME_STEP      = 3'd1,
        REG_INTERVAL_LIMIT = 3'd2,
        REG_WFQ_LIMIT      = 3'd3,
        REG_RATE_FLOOR     = 3'd4,
        REG_BURST_LIMIT    = 3'd5,
        REG_WFQ_BYPASS     = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CLASS_CBR     = 3'd0,
        CLASS_VBR_RT  = 3'd1,
        CLASS_VBR_NRT = 3'd2,
        CLASS_UBR_P   = 3'd3,
        CLASS_UBR     = 3'd4
    } service_class_t;

    typedef struct packed {
        logic [2:0]  service_class;
        logic [23:0] peak_rate;
        logic [23:0] min_rate;
        logic [23:0] sustained_rate;
        logic [15:0] max_burst;
        logic        clp_option;
        logic [3:0]  queue_index;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  queue_out;
        logic [15:0] peak_interval;
        logic [14:0] wfq_factor;
        logic        vbr_clp;
        logic [15:0] sustained_interval;
        logic [15:0] burst_tolerance;
    } out_word_t;

endpackage

// ===== rtl/core/atm_spc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
module atm_spc_div (
    input  logic                                clk,
    input  logic                                en,
    input  logic [atm_spc_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [atm_spc_pkg::DIVISOR_W-1:0]   divisor,
    output logic [atm_spc_pkg::DIVIDEND_W-1:0]  quotient
);

    localparam int NW = atm_spc_pkg::DIVIDEND_W;
    localparam int VW = atm_spc_pkg::DIVISOR_W;

    logic [VW-1:0] rem_reg [NW];
    logic [NW-1:0] dq_reg  [NW];
    logic [VW-1:0] dv_reg  [NW];

    genvar s;
    generate
        for (s = 0; s < NW; s++)
        begin : g_stage
            logic [VW-1:0] rem_in;
            logic [NW-1:0] dq_in;
            logic [VW-1:0] dv_in;
            logic [VW:0]   trial;
            logic [VW:0]   diff;
            logic          qbit;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign dq_in  = dividend;
                assign dv_in  = divisor;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[s-1];
                assign dq_in  = dq_reg[s-1];
                assign dv_in  = dv_reg[s-1];
            end

            // shift in the next dividend bit, subtract when it fits
            assign trial = {rem_in, dq_in[NW-1]};
            assign diff  = trial - {1'b0, dv_in};
            assign qbit  = (trial >= {1'b0, dv_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= qbit ? diff[VW-1:0] : trial[VW-1:0];
                    dq_reg[s]  <= {dq_in[NW-2:0], qbit};
                    dv_reg[s]  <= dv_in;
                end
            end
        end
    endgenerate

    assign quotient = dq_reg[NW-1];

endmodule

// ===== rtl/core/atm_shaper_parameter_calc.sv =====
// ATM shaper parameter calculator: takes one word per cycle while no finished result is held;
// each result passes through three 30-stage bit-per-stage dividers (peak
// interval, sustained interval, queueing factor) plus one input stage and three stages of
// clamping and burst arithmetic. The whole pipeline holds while a finished result waits.
module atm_shaper_parameter_calc #(
    parameter int QUEUE_COUNT = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [2:0]                         cfg_index,
    input  logic [atm_spc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  atm_spc_pkg::in_word_t              in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output atm_spc_pkg::out_word_t             out_data
);

    localparam int NW    = atm_spc_pkg::DIVIDEND_W;
    localparam int DEPTH = NW + 4;

    logic [31:0] bus_clock_hz_reg;
    logic [2:0]  time_step_reg;
    logic [15:0] interval_limit_reg;
    logic [13:0] wfq_limit_reg;
    logic [15:0] rate_floor_reg;
    logic [15:0] burst_limit_reg;
    logic [14:0] wfq_bypass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_clock_hz_reg   <= 32'd62500000;
            time_step_reg      <= 3'd1;
            interval_limit_reg <= 16'd65472;
            wfq_limit_reg      <= 14'd16383;
            rate_floor_reg     <= 16'd18;
            burst_limit_reg    <= 16'd64512;
            wfq_bypass_reg     <= 15'd16384;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                atm_spc_pkg::REG_BUS_CLOCK_HZ:   bus_clock_hz_reg   <= cfg_data;
                atm_spc_pkg::REG_TIME_STEP:      time_step_reg      <= cfg_data[2:0];
                atm_spc_pkg::REG_INTERVAL_LIMIT: interval_limit_reg <= cfg_data[15:0];
                atm_spc_pkg::REG_WFQ_LIMIT:      wfq_limit_reg      <= cfg_data[13:0];
                atm_spc_pkg::REG_RATE_FLOOR:     rate_floor_reg     <= cfg_data[15:0];
                atm_spc_pkg::REG_BURST_LIMIT:    burst_limit_reg    <= cfg_data[15:0];
                atm_spc_pkg::REG_WFQ_BYPASS:     wfq_bypass_reg     <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic [DEPTH-1:0] vld_reg;
    logic             advance;

    assign advance  = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // input stage: clock product (wraps at 32 bits) and factor numerator
    logic [31:0]           clk_prod;
    logic [26:0]           base_reg;
    logic [NW-1:0]         wprod_reg;
    atm_spc_pkg::in_word_t s0_reg;

    assign clk_prod = bus_clock_hz_reg * {29'd0, time_step_reg};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg    <= in_data;
            base_reg  <= clk_prod[31:5];
            wprod_reg <= {14'd0, rate_floor_reg} * {16'd0, wfq_limit_reg};
        end
    end

    logic [NW-1:0] q_peak;
    logic [NW-1:0] q_sust;
    logic [NW-1:0] q_wfq;

    atm_spc_div u_div_peak (
        .clk      (clk),
        .en       (advance),
        .dividend ({3'd0, base_reg}),
        .divisor  (s0_reg.peak_rate),
        .quotient (q_peak)
    );

    atm_spc_div u_div_sust (
        .clk      (clk),
        .en       (advance),
        .dividend ({3'd0, base_reg}),
        .divisor  (s0_reg.sustained_rate),
        .quotient (q_sust)
    );

    atm_spc_div u_div_wfq (
        .clk      (clk),
        .en       (advance),
        .dividend (wprod_reg),
        .divisor  (s0_reg.min_rate),
        .quotient (q_wfq)
    );

    // descriptor rides alongside the dividers
    atm_spc_pkg::in_word_t side_reg [NW];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= s0_reg;
            for (int i = 1; i < NW; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    atm_spc_pkg::in_word_t d;
    assign d = side_reg[NW-1];

    // fold the queue index into range, one entry per index value
    logic [3:0] qfold [16];

    genvar k;
    generate
        for (k = 0; k < 16; k++)
        begin : g_qfold
            assign qfold[k] = 4'(k % QUEUE_COUNT);
        end
    endgenerate

    // clamp stage
    logic [NW:0]  tp_sum;
    logic [NW:0]  ts_sum;
    logic [15:0]  tp_next;
    logic [15:0]  ts_next;
    logic [14:0]  wfq_next;
    logic         shaper_en;
    logic [15:0]  tp_reg;
    logic [15:0]  ts_reg;
    logic [14:0]  wfq_reg;
    logic         vbr_reg;
    logic         en1_reg;
    logic [15:0]  mbs_reg;
    logic [3:0]   q1_reg;

    assign tp_sum    = {1'b0, q_peak} + 31'd1;
    assign ts_sum    = {1'b0, q_sust} + 31'd1;
    assign shaper_en = (d.service_class == atm_spc_pkg::CLASS_VBR_RT
                     || d.service_class == atm_spc_pkg::CLASS_VBR_NRT)
                     && (d.sustained_rate != '0);

    always_comb
    begin
        if (d.peak_rate == '0)
            tp_next = '0;
        else if (tp_sum > {15'd0, interval_limit_reg})
            tp_next = interval_limit_reg;
        else
            tp_next = tp_sum[15:0];

        if (!shaper_en)
            ts_next = '0;
        else if (ts_sum > {15'd0, interval_limit_reg})
            ts_next = interval_limit_reg;
        else
            ts_next = ts_sum[15:0];

        case (d.service_class)
            atm_spc_pkg::CLASS_CBR,
            atm_spc_pkg::CLASS_VBR_RT:
                wfq_next = '0;
            atm_spc_pkg::CLASS_VBR_NRT,
            atm_spc_pkg::CLASS_UBR_P:
            begin
                if (d.min_rate == '0)
                    wfq_next = {1'b0, wfq_limit_reg};
                else if (q_wfq == '0)
                    wfq_next = 15'd1;
                else if (q_wfq > {16'd0, wfq_limit_reg})
                    wfq_next = {1'b0, wfq_limit_reg};
                else
                    wfq_next = q_wfq[14:0];
            end
            default:
                wfq_next = wfq_bypass_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tp_reg  <= tp_next;
            ts_reg  <= ts_next;
            wfq_reg <= wfq_next;
            vbr_reg <= shaper_en && d.clp_option;
            en1_reg <= shaper_en;
            mbs_reg <= d.max_burst;
            q1_reg  <= qfold[d.queue_index];
        end
    end

    // burst product stage
    logic signed [16:0] mbs_m1;
    logic signed [16:0] idiff;
    logic signed [33:0] prod_reg;
    atm_spc_pkg::out_word_t s2_reg;
    logic               en2_reg;

    assign mbs_m1 = signed'({1'b0, mbs_reg}) - 17'sd1;
    assign idiff  = signed'({1'b0, ts_reg}) - signed'({1'b0, tp_reg});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg                  <= 34'(mbs_m1 * idiff);
            en2_reg                   <= en1_reg;
            s2_reg.queue_out          <= q1_reg;
            s2_reg.peak_interval      <= tp_reg;
            s2_reg.wfq_factor         <= wfq_reg;
            s2_reg.vbr_clp            <= vbr_reg;
            s2_reg.sustained_interval <= ts_reg;
            s2_reg.burst_tolerance    <= '0;
        end
    end

    // divide by 64 toward zero and clamp
    logic [27:0]            quo;
    logic [15:0]            taus_next;
    atm_spc_pkg::out_word_t out_reg;

    assign quo = prod_reg[33:6];

    always_comb
    begin
        if (!en2_reg)
            taus_next = '0;
        else if (prod_reg <= -34'sd64)
            taus_next = burst_limit_reg;
        else if (prod_reg < 34'sd64)
            taus_next = 16'd1;
        else if (quo > {12'd0, burst_limit_reg})
            taus_next = burst_limit_reg;
        else
            taus_next = quo[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg                 <= s2_reg;
            out_reg.burst_tolerance <= taus_next;
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/atm_spc_checker.sv =====
// Port checker for the ATM shaper parameter calculator, with its bind
`include "atm_shaper_parameter_calc_macros.svh"

module atm_spc_checker #(
    parameter int QUEUE_COUNT = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input atm_spc_pkg::out_word_t out_data
);

    // an empty output never holds off the input
    `ATM_SPC_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
    // queue index always folded into range
    `ATM_SPC_ASSERT_NOW(a_queue_range, out_valid, 32'(out_data.queue_out) < QUEUE_COUNT)
    // a stalled result holds
    `ATM_SPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_data))

endmodule

bind atm_shaper_parameter_calc atm_spc_checker #(.QUEUE_COUNT(QUEUE_COUNT)) u_chk (.*);
